// ===== src/silhouette_edge_toggle_table_core_defines.svh =====
// Assertion macros for the edge toggle table.
`ifndef SILHOUETTE_EDGE_TOGGLE_TABLE_CORE_DEFINES_SVH
`define SILHOUETTE_EDGE_TOGGLE_TABLE_CORE_DEFINES_SVH

// Same-cycle check: when ante holds, cons must hold on that edge.
`define SETG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle check: when ante holds, cons must hold on the following edge.
`define SETG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/setg_pkg.sv =====
// Shared types and codes for the edge toggle table.
package setg_pkg;

    typedef logic [31:0] t_edge;  // vertex a in [15:0], vertex b in [31:16]

    localparam logic [1:0] MODE_TOGGLE = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_APPEND = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

endpackage

// ===== src/setg_cell.sv =====
// One storage cell of the rotating edge ring.
module setg_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  setg_pkg::t_edge i_data,
    output setg_pkg::t_edge o_data
);

    setg_pkg::t_edge r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== src/silhouette_edge_toggle_table_core.sv =====
// Top level of the edge toggle table: cell ring, scan sequencer and output register.
// Usage
//   s_axis_tuser carries the mode (toggle, read, clear), s_axis_tdata carries
//   vertex_a, vertex_b and entry_index. Every request yields one result on m_axis.
//   Edges live in a ring of MAX_EDGES cells with the last valid entry in the top
//   cell, so a removal knows its replacement value at the start. A toggle or read
//   rotates the ring one cell per cycle and compares at cell 0; the ring ends up
//   rotated to match the new count.
// Sequence (accept to result valid)
//   toggle remove or drop, read : SCAN over every cell, then DONE
//   toggle append               : SCAN over every cell, APPEND, then DONE
//   clear, unused mode          : DONE
// Requests
//   One request at a time; the next is taken the cycle after the result is
//   loaded into the output register.
// Reset
//   i_rst_n low (synchronous) empties the table and drops any pending result;
//   entry contents are not cleared.
// Stall
//   A finished result holds in the output register while m_axis_tready is low;
//   a new request is still accepted, and its result waits for the register.
`include "silhouette_edge_toggle_table_core_defines.svh"

module silhouette_edge_toggle_table_core #(
    parameter int MAX_EDGES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] vertex_a, [31:16] vertex_b, [37:32] entry_index, [39:38] zero
    input  logic [setg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [6:0] edge_total, [22:7] entry_vertex_a, [38:23] entry_vertex_b,
    // [39] was_removed, [40] full_drop, [41] bad_index, [47:42] zero
    output logic [setg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int CW = $clog2(MAX_EDGES + 1);  // count width
    localparam int SW = $clog2(MAX_EDGES);      // slot / step width
    localparam logic [SW-1:0] LAST_STEP = SW'(MAX_EDGES - 1);
    localparam logic [CW-1:0] CAP       = CW'(MAX_EDGES);

    setg_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [SW-1:0]    r_step;
    logic [SW-1:0]    r_slot;   // table slot currently in cell 0
    logic             r_hit;
    logic [1:0]       r_mode;
    logic [5:0]       r_idx;
    setg_pkg::t_edge  r_fwd, r_rev, r_last, r_rd;
    logic             r_rmv, r_drop, r_bad;
    logic             r_m_valid;
    logic [setg_pkg::OUT_TDATA_W-1:0] r_m_tdata;

    setg_pkg::t_edge  w_cell_q [MAX_EDGES];
    setg_pkg::t_edge  w_head, w_tail_in;
    logic             w_shift, w_valid, w_match, w_found, w_last, w_room;
    logic             w_toggle, w_accept, w_out_free;
    logic [SW-1:0]    w_slot_init;
    logic [15:0]      w_ra, w_rb;

    // ---- cell ring: cell g takes from cell g+1, top cell takes the tail value
    for (genvar g = 0; g < MAX_EDGES; g++) begin : g_cell
        if (g == MAX_EDGES - 1) begin : g_top
            setg_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_data (w_tail_in),
                .o_data (w_cell_q[g])
            );
        end else begin : g_mid
            setg_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_data (w_cell_q[g+1]),
                .o_data (w_cell_q[g])
            );
        end
    end

    assign s_axis_tready = (r_state == setg_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // ---- scan datapath at cell 0
    always_comb begin
        w_head   = w_cell_q[0];
        w_toggle = (r_mode == setg_pkg::MODE_TOGGLE);
        w_valid  = CW'(r_slot) < r_count;
        w_last   = (r_step == LAST_STEP);
        w_room   = (r_count < CAP);
        w_match  = (r_state == setg_pkg::ST_SCAN) && w_toggle && w_valid && !r_hit
                   && ((w_head == r_fwd) || (w_head == r_rev));
        w_found  = r_hit || w_match;
        // A removal stops one shift short, which moves the ring to count - 1.
        w_shift  = ((r_state == setg_pkg::ST_SCAN) && !(w_toggle && w_last && w_found))
                   || (r_state == setg_pkg::ST_APPEND);
        // Slot "count" is first out of cell 0; the appended edge is written there.
        if ((r_state == setg_pkg::ST_SCAN) && w_toggle && (r_step == '0) && w_room) begin
            w_tail_in = r_fwd;
        end else if (w_match) begin
            w_tail_in = r_last;
        end else begin
            w_tail_in = w_head;
        end
        w_slot_init = (r_count == CAP) ? '0 : SW'(r_count);
        w_ra = (r_mode == setg_pkg::MODE_READ && !r_bad) ? r_rd[15:0]  : 16'd0;
        w_rb = (r_mode == setg_pkg::MODE_READ && !r_bad) ? r_rd[31:16] : 16'd0;
    end

    // ---- sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            setg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (s_axis_tuser)
                        setg_pkg::MODE_TOGGLE,
                        setg_pkg::MODE_READ: n_state = setg_pkg::ST_SCAN;
                        setg_pkg::MODE_CLEAR: begin
                            n_state = setg_pkg::ST_DONE;
                            n_count = '0;
                        end
                        default: n_state = setg_pkg::ST_DONE;
                    endcase
                end
            end
            setg_pkg::ST_SCAN: begin
                if (w_last) begin
                    n_state = setg_pkg::ST_DONE;
                    if (w_toggle) begin
                        if (w_found) begin
                            n_count = r_count - CW'(1);
                        end else if (w_room) begin
                            n_count = r_count + CW'(1);
                            n_state = setg_pkg::ST_APPEND;
                        end
                    end
                end
            end
            setg_pkg::ST_APPEND: n_state = setg_pkg::ST_DONE;
            setg_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = setg_pkg::ST_IDLE;
                end
            end
            default: n_state = setg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= setg_pkg::ST_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == setg_pkg::ST_DONE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // ---- request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= s_axis_tuser;
            r_fwd  <= s_axis_tdata[31:0];
            r_rev  <= {s_axis_tdata[15:0], s_axis_tdata[31:16]};
            r_idx  <= s_axis_tdata[37:32];
            r_last <= w_cell_q[MAX_EDGES-1];
            r_step <= '0;
            r_slot <= w_slot_init;
            r_hit  <= 1'b0;
            r_rmv  <= 1'b0;
            r_drop <= 1'b0;
            r_bad  <= (s_axis_tuser == setg_pkg::MODE_READ)
                      && !(32'(s_axis_tdata[37:32]) < 32'(r_count));
        end else if (r_state == setg_pkg::ST_SCAN) begin
            r_step <= r_step + SW'(1);
            r_slot <= (r_slot == LAST_STEP) ? '0 : r_slot + SW'(1);
            if (w_match) begin
                r_hit <= 1'b1;
            end
            if (r_mode == setg_pkg::MODE_READ && 32'(r_slot) == 32'(r_idx)) begin
                r_rd <= w_head;
            end
            if (w_last && w_toggle) begin
                r_rmv  <= w_found;
                r_drop <= !w_found && !w_room;
            end
        end
        if (r_state == setg_pkg::ST_DONE && w_out_free) begin
            r_m_tdata <= {6'd0, r_bad, r_drop, r_rmv, w_rb, w_ra, 7'(r_count)};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;

    // ---- checks
    `SETG_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CAP, "edge count above capacity")
    `SETG_ASSERT_NEXT(a_remove_dec,
        (r_state == setg_pkg::ST_SCAN) && w_toggle && w_last && w_found,
        r_count == $past(r_count) - CW'(1), "removal did not lower the count")
    `SETG_ASSERT_NEXT(a_accept_busy, w_accept, r_state != setg_pkg::ST_IDLE,
        "sequencer stayed idle after a request")

endmodule

// ===== test/silhouette_edge_toggle_table_core_tb.sv =====
// Self-checking bench for the edge toggle table: directed and random requests against a scoreboard.

typedef struct {
    logic [1:0]  mode;
    logic [15:0] va;
    logic [15:0] vb;
    logic [5:0]  idx;
} t_edge_req;

typedef struct {
    logic [6:0]  total;
    logic [15:0] ra;
    logic [15:0] rb;
    logic        removed;
    logic        dropped;
    logic        bad;
} t_edge_rsp;

class edge_table_scoreboard #(int DEPTH = 64);
    logic [31:0] entries [DEPTH];   // vertex a low, vertex b high
    int unsigned count;
    t_edge_rsp   expected_q [$];
    int unsigned mismatches;

    function new();
        count      = 0;
        mismatches = 0;
    endfunction

    // Update the shadow table for one accepted request and queue its result.
    function void note_request(t_edge_req req);
        t_edge_rsp   rsp;
        logic [31:0] fwd;
        logic [31:0] rev;
        int          hit;
        int          i;
        rsp.ra      = '0;
        rsp.rb      = '0;
        rsp.removed = 1'b0;
        rsp.dropped = 1'b0;
        rsp.bad     = 1'b0;
        case (req.mode)
            setg_pkg::MODE_TOGGLE: begin
                fwd = {req.vb, req.va};
                rev = {req.va, req.vb};
                hit = -1;
                for (i = 0; i < int'(count); i++) begin
                    if (hit < 0 && (entries[i] == fwd || entries[i] == rev)) hit = i;
                end
                if (hit >= 0) begin
                    entries[hit] = entries[count - 1];
                    count--;
                    rsp.removed = 1'b1;
                end else if (count < DEPTH) begin
                    entries[count] = fwd;
                    count++;
                end else begin
                    rsp.dropped = 1'b1;
                end
            end
            setg_pkg::MODE_READ: begin
                if (req.idx < count) begin
                    rsp.ra = entries[req.idx][15:0];
                    rsp.rb = entries[req.idx][31:16];
                end else begin
                    rsp.bad = 1'b1;
                end
            end
            setg_pkg::MODE_CLEAR: begin
                count = 0;
            end
            default: begin
            end
        endcase
        rsp.total = 7'(count);
        expected_q.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Unpack one result beat and compare it against the oldest prediction.
    function void check_result(logic [setg_pkg::OUT_TDATA_W-1:0] data);
        t_edge_rsp want;
        if (expected_q.size() == 0) begin
            $display("%0t: result %h with nothing expected", $time, data);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("edge_total",     16'(want.total),   16'(data[6:0]));
        compare_field("entry_vertex_a", want.ra,           data[22:7]);
        compare_field("entry_vertex_b", want.rb,           data[38:23]);
        compare_field("was_removed",    16'(want.removed), 16'(data[39]));
        compare_field("full_drop",      16'(want.dropped), 16'(data[40]));
        compare_field("bad_index",      16'(want.bad),     16'(data[41]));
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction
endclass

module silhouette_edge_toggle_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_EDGES       = 64;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         RANDOM_REQUESTS = 1400;
    // Slowest request is a full ring scan and an append, plus the longest gap
    // or stall on either side; this is many times that.
    localparam int         WATCHDOG_LIMIT  = 4000;

    // Random phases steer the table level: fill toward full, churn around
    // the middle, drain toward empty.
    typedef enum {PH_FILL, PH_CHURN, PH_DRAIN} t_phase;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [15:0] vertex_a, [31:16] vertex_b, [37:32] entry_index, [39:38] zero
    logic [setg_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] mode
    logic [1:0]             s_axis_tuser  = setg_pkg::MODE_TOGGLE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [6:0] edge_total, [22:7] entry_vertex_a, [38:23] entry_vertex_b,
    // [39] was_removed, [40] full_drop, [41] bad_index, [47:42] zero
    logic [setg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    edge_table_scoreboard #(MAX_EDGES) sb;

    bit          steady     = 1'b0;   // phase with no idling on either side
    int unsigned stall_left = 0;
    int unsigned stall_len  = 0;
    int unsigned quiet      = 0;

    silhouette_edge_toggle_table_core #(
        .MAX_EDGES(MAX_EDGES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic t_edge_req mk(logic [1:0] mode, logic [15:0] va, logic [15:0] vb,
                                     logic [5:0] idx);
        t_edge_req req;
        req.mode = mode;
        req.va   = va;
        req.vb   = vb;
        req.idx  = idx;
        return req;
    endfunction

    // Present one request, hold it until taken, then hand it to the scoreboard.
    // With no gap, tvalid simply stays high for the next request.
    task automatic send(input t_edge_req req);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.mode;
        s_axis_tdata  <= {2'b00, req.idx, req.vb, req.va};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_request(req);
    endtask

    // One random request, weighted by phase. Toggles of stored edges come
    // from the shadow table so removals land in either orientation.
    task automatic random_request(input t_phase ph);
        t_edge_req   req;
        logic [31:0] stored;
        int unsigned r;
        int unsigned k;
        int          fresh_w;
        int          old_w;
        int          read_w;
        int          clear_w;
        case (ph)
            PH_FILL:  begin fresh_w = 70; old_w = 10; read_w = 16; clear_w = 0; end
            PH_CHURN: begin fresh_w = 40; old_w = 35; read_w = 20; clear_w = 2; end
            default:  begin fresh_w = 15; old_w = 55; read_w = 25; clear_w = 2; end
        endcase
        req = mk(setg_pkg::MODE_TOGGLE, 16'($urandom), 16'($urandom),
                 6'($urandom_range(63)));
        r = $urandom_range(99);
        if (r < fresh_w || (r < fresh_w + old_w && sb.count == 0)) begin
            k = $urandom_range(9);
            if (k == 0) begin
                req.vb = req.va;                      // degenerate edge
            end else if (k == 1) begin
                req.va = 16'($urandom_range(3));      // tiny pool, chance hits
                req.vb = 16'($urandom_range(3));
            end
        end else if (r < fresh_w + old_w) begin
            stored = sb.entries[$urandom_range(sb.count - 1)];
            if ($urandom_range(1) == 0) begin
                req.va = stored[15:0];
                req.vb = stored[31:16];
            end else begin
                req.va = stored[31:16];
                req.vb = stored[15:0];
            end
        end else if (r < fresh_w + old_w + read_w) begin
            req.mode = setg_pkg::MODE_READ;
            if (sb.count != 0 && $urandom_range(99) < 80)
                req.idx = 6'($urandom_range(sb.count - 1));
        end else if (r < fresh_w + old_w + read_w + clear_w) begin
            req.mode = setg_pkg::MODE_CLEAR;
        end else begin
            req.mode = MODE_UNUSED;
        end
        send(req);
    endtask

    // Result side: check on every accepted beat, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            stall_len = pick_gap();
            if (stall_len == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_len - 1;
            end
        end
    end

    // Watchdog: any request or result handshake restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
            quiet <= 0;
        end else if (quiet + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        t_phase      ph;
        int unsigned sent;
        int unsigned len;
        int unsigned n;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty read, vertex extremes, degenerate edges, reversed
        // match, removal of the last slot, removal from the middle, unused
        // mode, clear and refill.
        send(mk(setg_pkg::MODE_READ,   16'h0000, 16'h0000, 6'd0));
        send(mk(setg_pkg::MODE_TOGGLE, 16'h0000, 16'h0000, 6'd63));
        send(mk(setg_pkg::MODE_TOGGLE, 16'hFFFF, 16'hFFFF, 6'd0));
        send(mk(setg_pkg::MODE_TOGGLE, 16'h0000, 16'hFFFF, 6'd0));
        send(mk(setg_pkg::MODE_READ,   16'h0000, 16'h0000, 6'd1));
        send(mk(setg_pkg::MODE_READ,   16'hFFFF, 16'hFFFF, 6'd2));
        send(mk(setg_pkg::MODE_READ,   16'h0000, 16'h0000, 6'd63));
        send(mk(setg_pkg::MODE_READ,   16'h0000, 16'h0000, 6'd3));
        send(mk(setg_pkg::MODE_TOGGLE, 16'hFFFF, 16'h0000, 6'd0));   // reversed, last slot
        send(mk(setg_pkg::MODE_TOGGLE, 16'h0000, 16'h0000, 6'd0));   // slot 0, top moves down
        send(mk(setg_pkg::MODE_READ,   16'h0000, 16'h0000, 6'd0));
        send(mk(setg_pkg::MODE_TOGGLE, 16'h1234, 16'hABCD, 6'd0));
        send(mk(setg_pkg::MODE_TOGGLE, 16'h5555, 16'hAAAA, 6'd0));
        send(mk(setg_pkg::MODE_TOGGLE, 16'h1234, 16'hABCD, 6'd0));   // middle removal
        send(mk(setg_pkg::MODE_READ,   16'h0000, 16'h0000, 6'd1));
        send(mk(MODE_UNUSED,           16'hFFFF, 16'hFFFF, 6'd63));
        send(mk(setg_pkg::MODE_CLEAR,  16'hFFFF, 16'hFFFF, 6'd63));
        send(mk(setg_pkg::MODE_READ,   16'h0000, 16'h0000, 6'd0));
        send(mk(setg_pkg::MODE_TOGGLE, 16'h00FF, 16'hFF00, 6'd0));   // overwrite after clear
        send(mk(setg_pkg::MODE_READ,   16'hFFFF, 16'hFFFF, 6'd0));

        // Random phases; the first one fills the table so drops show up early.
        ph   = PH_FILL;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            len    = $urandom_range(200, 60);
            steady = ($urandom_range(3) == 0);
            for (n = 0; n < len; n++) random_request(ph);
            sent += len;
            ph = t_phase'($urandom_range(2));
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        // Stray results would show up before this wait ends, which outlasts a full ring scan.
        repeat (MAX_EDGES + 8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/setg_pkg.sv
src/setg_cell.sv
src/silhouette_edge_toggle_table_core.sv
test/silhouette_edge_toggle_table_core_tb.sv
